/* hdl/xld_pkg.sv */
// ---------------------------------------------------------------------------
// Xiph lace deframer package
// Item types for both channels, the status codes and the sizing defaults
// shared by the deframer and its output buffer.
// ---------------------------------------------------------------------------
package xld_pkg;

    // Sizing defaults for the top-level parameters.
    localparam int MAX_LACES_DEF = 256;
    localparam int SIZE_BITS_DEF = 24;

    // Fixed field widths of the item formats.
    localparam int BYTE_W      = 8;
    localparam int LACE_W      = 8;
    localparam int LACE_SIZE_W = 24;

    // Largest byte value, which continues a lace size.
    localparam logic [BYTE_W-1:0] SIZE_CONT = 8'hFF;

    // Frame status reported with the last byte.
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_END_IN_SIZES = 2'd1,
        ST_TOO_SHORT    = 2'd2,
        ST_OVERFLOW     = 2'd3
    } status_t;

    // One input item: a frame byte and its end flag.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_last;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0]      byte_out;
        logic                   is_payload;
        logic [LACE_W-1:0]      lace_index;
        logic                   lace_first;
        logic                   size_done;
        logic [LACE_SIZE_W-1:0] lace_size;
        logic                   frame_done;
        status_t                status;
    } out_item_t;

endpackage

/* hdl/xld_lace_mem.sv */
// ---------------------------------------------------------------------------
// Lace entry memory
// Single-port-write, single-port-read synchronous memory that holds the size
// and lace number of each stored lace. Registered read with write-to-read
// forwarding when both ports hit the same entry in one cycle.
// ---------------------------------------------------------------------------
module xld_lace_mem #(
    parameter int DEPTH   = 256,
    parameter int ENTRY_W = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [ENTRY_W-1:0]       wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ENTRY_W-1:0]       rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a write to the same entry in this cycle is passed through.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/xld_out_skid.sv */
// ---------------------------------------------------------------------------
// Output register with skid stage
// Holds finished result items toward the downstream side. The skid entry
// catches the item that arrives while the output is stalled, so the stall
// back to the producer comes straight from a register.
// ---------------------------------------------------------------------------
module xld_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  xld_pkg::out_item_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output xld_pkg::out_item_t out_data
);

    import xld_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_item_t out_data_reg;
    out_item_t out_data_next;
    out_item_t skid_data_reg;
    out_item_t skid_data_next;
    logic      out_free;

    // Next state: refill the output from the skid entry first.
    always_comb
    begin
        out_free        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Item data.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/xiph_lace_deframer.sv */
// ---------------------------------------------------------------------------
// Xiph lace deframer
// Results: each result item is registered in the output buffer.
// Throughput: one item per cycle while in_stall is low; the size memory is
// read with next-pointer lookahead, so its registered read keeps pace.
// Reset: asynchronous; clears the control state, not the lace memory.
// ---------------------------------------------------------------------------
module xiph_lace_deframer #(
    parameter int MAX_LACES = xld_pkg::MAX_LACES_DEF,
    parameter int SIZE_BITS = xld_pkg::SIZE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  xld_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output xld_pkg::out_item_t out_data
);

    import xld_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_LACES);
    localparam int CNT_W   = $clog2(MAX_LACES + 1);
    localparam int ENTRY_W = SIZE_BITS + LACE_W;

    // Frame parsing phases.
    typedef enum logic [2:0] {
        PH_COUNT   = 3'b001,
        PH_SIZES   = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [LACE_W-1:0]    declared_reg;
    logic [LACE_W-1:0]    declared_next;
    logic [LACE_W-1:0]    sizes_reg;
    logic [LACE_W-1:0]    sizes_next;
    logic [SIZE_BITS-1:0] acc_reg;
    logic [SIZE_BITS-1:0] acc_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic [CNT_W-1:0]     entries_reg;
    logic [CNT_W-1:0]     entries_next;
    logic [CNT_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]     ptr_next;
    logic [SIZE_BITS-1:0] left_reg;
    logic [SIZE_BITS-1:0] left_next;
    logic [LACE_W-1:0]    cur_reg;
    logic [LACE_W-1:0]    cur_next;
    logic                 fresh_reg;
    logic                 fresh_next;

    logic                 in_acc;
    logic                 skid_full;
    out_item_t            res;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   wr_data;
    logic [ENTRY_W-1:0]   rd_data;
    logic [SIZE_BITS:0]   sum;
    logic [SIZE_BITS-1:0] acc_sat;
    logic [SIZE_BITS-1:0] left_eff;
    logic [SIZE_BITS-1:0] left_dec;

    assign in_stall = skid_full;
    assign in_acc   = in_valid && !skid_full;

    // Size accumulation with saturation at the counter's full scale.
    assign sum     = {1'b0, acc_reg} + (SIZE_BITS + 1)'(in_data.data_byte);
    assign acc_sat = sum[SIZE_BITS] ? {SIZE_BITS{1'b1}} : sum[SIZE_BITS-1:0];

    // Remaining bytes of the current lace; a fresh lace loads its stored size.
    assign left_eff = fresh_reg ? rd_data[SIZE_BITS-1:0] : left_reg;
    assign left_dec = (left_eff != '0) ? (left_eff - SIZE_BITS'(1)) : '0;

    // Entry write: one stored size with its lace number.
    assign wr_data = {sizes_reg, acc_sat};

    // Parser next state and result item.
    always_comb
    begin
        phase_next    = phase_reg;
        declared_next = declared_reg;
        sizes_next    = sizes_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        entries_next  = entries_reg;
        ptr_next      = ptr_reg;
        left_next     = left_reg;
        cur_next      = cur_reg;
        fresh_next    = fresh_reg;
        wr_en         = 1'b0;
        res            = '0;
        res.byte_out   = in_data.data_byte;
        res.frame_done = in_data.frame_last;
        res.status     = ST_OK;

        if (in_acc)
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    declared_next = in_data.data_byte;
                    sizes_next    = '0;
                    acc_next      = '0;
                    ovf_next      = 1'b0;
                    entries_next  = '0;
                    ptr_next      = '0;
                    fresh_next    = 1'b1;
                    phase_next    = (in_data.data_byte == '0) ? PH_PAYLOAD : PH_SIZES;
                    if (in_data.frame_last)
                    begin
                        res.status = (in_data.data_byte == '0) ? ST_OK : ST_END_IN_SIZES;
                    end
                end
                PH_SIZES:
                begin
                    acc_next = acc_sat;
                    ovf_next = ovf_reg || sum[SIZE_BITS];
                    if (in_data.data_byte != SIZE_CONT)
                    begin
                        res.size_done = 1'b1;
                        res.lace_size = LACE_SIZE_W'(acc_sat);
                        // Zero-length laces and laces beyond capacity are not stored.
                        if ((acc_sat != '0) && (entries_reg < CNT_W'(MAX_LACES)))
                        begin
                            wr_en        = 1'b1;
                            entries_next = entries_reg + CNT_W'(1);
                        end
                        sizes_next = sizes_reg + LACE_W'(1);
                        acc_next   = '0;
                        if ((sizes_reg + LACE_W'(1)) >= declared_reg)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    if (in_data.frame_last)
                    begin
                        if (phase_next == PH_SIZES)
                        begin
                            res.status = ST_END_IN_SIZES;
                        end
                        else if (ovf_next)
                        begin
                            res.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            res.status = (ptr_reg < entries_next) ? ST_TOO_SHORT : ST_OK;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    res.is_payload = 1'b1;
                    res.lace_first = fresh_reg;
                    fresh_next     = 1'b0;
                    if (ptr_reg < entries_reg)
                    begin
                        // A sized lace: count its bytes down.
                        if (fresh_reg)
                        begin
                            cur_next = rd_data[ENTRY_W-1:SIZE_BITS];
                        end
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            ptr_next   = ptr_reg + CNT_W'(1);
                            fresh_next = 1'b1;
                        end
                    end
                    else if (fresh_reg)
                    begin
                        // The last lace takes the rest of the frame.
                        cur_next = declared_reg;
                    end
                    res.lace_index = cur_next;
                    if (in_data.frame_last)
                    begin
                        if (ovf_reg)
                        begin
                            res.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            res.status = (ptr_next < entries_reg) ? ST_TOO_SHORT : ST_OK;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_COUNT;
                end
            endcase

            // The frame's last byte starts a new frame.
            if (in_data.frame_last)
            begin
                phase_next    = PH_COUNT;
                declared_next = '0;
                sizes_next    = '0;
                acc_next      = '0;
                ovf_next      = 1'b0;
                entries_next  = '0;
                ptr_next      = '0;
                left_next     = '0;
                cur_next      = '0;
                fresh_next    = 1'b1;
            end
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COUNT;
            declared_reg <= '0;
            sizes_reg    <= '0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            entries_reg  <= '0;
            ptr_reg      <= '0;
            left_reg     <= '0;
            cur_reg      <= '0;
            fresh_reg    <= 1'b1;
        end
        else
        begin
            phase_reg    <= phase_next;
            declared_reg <= declared_next;
            sizes_reg    <= sizes_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
            entries_reg  <= entries_next;
            ptr_reg      <= ptr_next;
            left_reg     <= left_next;
            cur_reg      <= cur_next;
            fresh_reg    <= fresh_next;
        end
    end

    // Lace memory, read one entry ahead at the next pointer value.
    xld_lace_mem #(
        .DEPTH   (MAX_LACES),
        .ENTRY_W (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entries_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (ptr_next[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Result buffering toward the downstream side.
    xld_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_acc),
        .push_data (res),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* tb/sv/xiph_lace_deframer_tb.sv */
// ---------------------------------------------------------------------------
// Xiph lace deframer testbench
// Feeds laced frames one byte per item and predicts every result item: the
// header/payload tag, lace index, first-byte flag, completed sizes and the
// frame status. Directed frames cover single laces, early ends, zero-length
// laces, size continuations and the largest lace count. Random frames follow,
// mostly well formed, with random gaps and stalls on both sides and one long
// output hold-off.
// ---------------------------------------------------------------------------
module xiph_lace_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import xld_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_BYTES = 100;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 2_000_000;

    // Tracks the deframer's header parsing and lace bookkeeping, queues the
    // result each accepted byte should produce and checks the results.
    class lace_tracker;
        typedef enum logic [1:0] {AWAIT_COUNT, READ_SIZES, PASS_PAYLOAD} stage_t;

        localparam logic [SIZE_BITS_DEF-1:0] SIZE_MAX = '1;

        stage_t                   stage;
        logic [LACE_W-1:0]        declared;
        logic [8:0]               sizes_seen;
        logic [SIZE_BITS_DEF-1:0] acc;
        bit                       ovf;
        logic [SIZE_BITS_DEF-1:0] len_mem [MAX_LACES_DEF];
        logic [LACE_W-1:0]        num_mem [MAX_LACES_DEF];
        int unsigned              stored;
        int unsigned              ptr;
        logic [SIZE_BITS_DEF-1:0] left;
        logic [LACE_W-1:0]        cur;
        bit                       fresh;
        out_item_t                want_q[$];

        int errors;
        int results;
        int payload_bytes;
        int sizes_done;
        int frames;
        int ends_by_status[4];

        function new();
            foreach (len_mem[i])
            begin
                len_mem[i] = '0;
                num_mem[i] = '0;
            end
            foreach (ends_by_status[i])
                ends_by_status[i] = 0;
            errors = 0;
            results = 0;
            payload_bytes = 0;
            sizes_done = 0;
            frames = 0;
            restart();
        endfunction

        function void restart();
            stage = AWAIT_COUNT;
            declared = '0;
            sizes_seen = '0;
            acc = '0;
            ovf = 1'b0;
            stored = 0;
            ptr = 0;
            left = '0;
            cur = '0;
            fresh = 1'b1;
        endfunction

        function status_t end_status();
            if (ovf)
                return ST_OVERFLOW;
            return (ptr < stored) ? ST_TOO_SHORT : ST_OK;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        // Works out the result for one accepted frame byte.
        function void note_byte(in_item_t it);
            out_item_t            r;
            logic [SIZE_BITS_DEF:0] sum;
            r = '0;
            r.byte_out = it.data_byte;
            r.frame_done = it.frame_last;
            r.status = ST_OK;
            case (stage)
                AWAIT_COUNT:
                begin
                    declared = it.data_byte;
                    sizes_seen = '0;
                    acc = '0;
                    ovf = 1'b0;
                    stored = 0;
                    ptr = 0;
                    fresh = 1'b1;
                    stage = (it.data_byte == 0) ? PASS_PAYLOAD : READ_SIZES;
                    if (it.frame_last && it.data_byte != 0)
                        r.status = ST_END_IN_SIZES;
                end
                READ_SIZES:
                begin
                    // Sizes saturate rather than wrap.
                    sum = {1'b0, acc} + it.data_byte;
                    if (sum > SIZE_MAX)
                    begin
                        acc = SIZE_MAX;
                        ovf = 1'b1;
                    end
                    else
                        acc = sum[SIZE_BITS_DEF-1:0];
                    if (it.data_byte != SIZE_CONT)
                    begin
                        r.size_done = 1'b1;
                        r.lace_size = acc;
                        sizes_done++;
                        // Empty laces are reported but never stored.
                        if (acc != 0 && stored < MAX_LACES_DEF)
                        begin
                            len_mem[stored] = acc;
                            num_mem[stored] = sizes_seen[LACE_W-1:0];
                            stored++;
                        end
                        sizes_seen++;
                        acc = '0;
                        if (sizes_seen >= declared)
                            stage = PASS_PAYLOAD;
                    end
                    if (it.frame_last)
                        r.status = (stage == READ_SIZES) ? ST_END_IN_SIZES : end_status();
                end
                default:
                begin
                    r.is_payload = 1'b1;
                    payload_bytes++;
                    if (ptr < stored)
                    begin
                        if (fresh)
                        begin
                            left = len_mem[ptr];
                            cur = num_mem[ptr];
                        end
                        r.lace_first = fresh;
                        fresh = 1'b0;
                        if (left != 0)
                            left--;
                        if (left == 0)
                        begin
                            ptr++;
                            fresh = 1'b1;
                        end
                    end
                    else
                    begin
                        // The last lace takes whatever is left of the frame.
                        if (fresh)
                            cur = declared;
                        r.lace_first = fresh;
                        fresh = 1'b0;
                    end
                    r.lace_index = cur;
                    if (it.frame_last)
                        r.status = end_status();
                end
            endcase
            if (it.frame_last)
            begin
                frames++;
                ends_by_status[r.status]++;
                restart();
            end
            want_q = {want_q, r};
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h, expected %0h",
                                 results, name, got, want));
        endtask

        // Compares one accepted result with the oldest expectation.
        task check_item(out_item_t got);
            out_item_t want;
            if (want_q.size() == 0)
            begin
                report($sformatf("result with nothing expected, byte %0h", got.byte_out));
                return;
            end
            want = want_q.pop_front();
            compare_field("byte_out", 32'(got.byte_out), 32'(want.byte_out));
            compare_field("is_payload", 32'(got.is_payload), 32'(want.is_payload));
            compare_field("lace_index", 32'(got.lace_index), 32'(want.lace_index));
            compare_field("lace_first", 32'(got.lace_first), 32'(want.lace_first));
            compare_field("size_done", 32'(got.size_done), 32'(want.size_done));
            compare_field("lace_size", 32'(got.lace_size), 32'(want.lace_size));
            compare_field("frame_done", 32'(got.frame_done), 32'(want.frame_done));
            compare_field("status", 32'(got.status), 32'(want.status));
            results++;
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    lace_tracker book;
    logic [BYTE_W-1:0] frame_bytes[$];
    logic        hold_off;
    int          bytes_sent = 0;
    int          cycles = 0;
    int          in_stall_cycles = 0;

    xiph_lace_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Cycle count, input backpressure count and the run's time limit.
    always @(posedge clk)
    begin
        cycles++;
        if (in_valid && in_stall)
            in_stall_cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, book.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly no gap, some short ones and a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Appends one byte to the frame under construction.
    function automatic void add_byte(logic [BYTE_W-1:0] b);
        frame_bytes = {frame_bytes, b};
    endfunction

    // Appends a lace size in laced form: a run of 255s and a final byte.
    function automatic void put_size(int unsigned n);
        while (n >= 255)
        begin
            add_byte(SIZE_CONT);
            n -= 255;
        end
        add_byte(n[BYTE_W-1:0]);
    endfunction

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 0;
        if (r < 92)
            return $urandom_range(1, 6);
        return $urandom_range(250, 300);
    endfunction

    // Offers one item and waits for it to be taken. The valid is only lowered
    // when a gap follows, so it never toggles within one time step.
    task automatic send_byte(input in_item_t item, input bit quiet);
        int unsigned gap;
        gap = (quiet || hold_off) ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        book.note_byte(item);
        bytes_sent++;
    endtask

    // Sends the bytes gathered in frame_bytes as one frame.
    task automatic send_frame(input bit quiet);
        in_item_t item;
        foreach (frame_bytes[i])
        begin
            item.data_byte  = frame_bytes[i];
            item.frame_last = (i == frame_bytes.size() - 1);
            send_byte(item, quiet);
        end
        frame_bytes.delete();
    endtask

    // Builds one random frame: mostly well formed, some cut short, some noise.
    function automatic void build_random_frame();
        int unsigned kind;
        int unsigned laces;
        int unsigned total;
        int unsigned plen;
        int unsigned cut;
        int unsigned sz;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 8))
                add_byte(BYTE_W'($urandom_range(0, 255)));
            return;
        end
        laces = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        add_byte(BYTE_W'(laces - 1));
        total = 0;
        for (int i = 0; i < laces - 1; i++)
        begin
            sz = pick_size();
            put_size(sz);
            total += sz;
        end
        plen = total + $urandom_range(0, 5);
        repeat (plen)
            add_byte(BYTE_W'($urandom_range(0, 255)));
        if (frame_bytes.size() == 0)
            add_byte(BYTE_W'($urandom_range(0, 255)));
        if (kind < 30)
        begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
    endfunction

    // Result side: checks accepted results and stalls at random, in phases
    // of no stalling, light and heavy stalling, with occasional long runs.
    initial
    begin : receiver
        int unsigned pct;
        int unsigned run_left;
        int unsigned tick;
        pct = 0;
        run_left = 0;
        tick = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                book.check_item(out_data);
            tick++;
            if (tick % 128 == 0)
            begin
                case ($urandom_range(0, 3))
                    0, 1: pct = 0;
                    2: pct = 25;
                    default: pct = 60;
                endcase
            end
            if (run_left > 0)
                run_left--;
            else if ($urandom_range(0, 499) == 0)
                run_left = $urandom_range(20, 80);
            out_stall <= hold_off || run_left > 0 || ($urandom_range(0, 99) < pct);
        end
    end

    // One long output hold-off while the sender keeps offering items, so the
    // block fills up and pushes back on its input.
    initial
    begin : pressure
        hold_off = 1'b0;
        wait (bytes_sent >= 150);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : main
        int target;
        int unsigned sz;
        int unsigned total;
        book = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single lace with extreme payload values.
        frame_bytes = '{8'h00, 8'h00, 8'hFF};
        send_frame(1'b0);
        // Frame that is only a count byte, with and without more laces owed.
        frame_bytes = '{8'h00};
        send_frame(1'b0);
        frame_bytes = '{8'hFF};
        send_frame(1'b0);
        // Frame ending inside a size run.
        frame_bytes = '{8'h02, 8'hFF};
        send_frame(1'b0);
        // Zero-length lace ahead of a two-byte lace and the remainder lace.
        frame_bytes = '{8'h02, 8'h00, 8'h02, 8'hA5, 8'h5A, 8'h3C};
        send_frame(1'b1);
        // Continued size of 256, frame cut short.
        frame_bytes = '{8'h01, 8'hFF, 8'h01, 8'h01, 8'h02, 8'h03};
        send_frame(1'b0);
        // Sized lace filled exactly, last lace left empty.
        frame_bytes = '{8'h01, 8'h03, 8'h7E, 8'h81, 8'hC3};
        send_frame(1'b0);

        // Random frames, some sent back to back.
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            build_random_frame();
            send_frame($urandom_range(0, 3) == 0);
        end

        // Largest lace count, sizes mostly empty.
        add_byte(8'hFF);
        total = 0;
        repeat (255)
        begin
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
            put_size(sz);
            total += sz;
        end
        repeat (total + 2)
            add_byte(BYTE_W'($urandom_range(0, 255)));
        send_frame(1'b0);

        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results over %0d frames: %0d payload bytes, %0d sizes.",
                 book.results, book.frames, book.payload_bytes, book.sizes_done);
        $display("Frame ends ok/in sizes/too short/overflow: %0d/%0d/%0d/%0d;",
                 book.ends_by_status[ST_OK], book.ends_by_status[ST_END_IN_SIZES],
                 book.ends_by_status[ST_TOO_SHORT], book.ends_by_status[ST_OVERFLOW]);
        $display("%0d cycles with the input held off.", in_stall_cycles);
        if (book.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
